@@ rtl/ped_pkg.sv @@
// Shared types and constants for the percent-escape decoder.
`timescale 1ns / 1ps

package ped_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int APB_ADDR_W      = 3;
  localparam int CP_W            = 21;

  typedef enum logic [2:0] {
    ST_BYTE       = 3'd0,
    ST_END        = 3'd1,
    ST_BADHEX     = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_DISALLOWED = 3'd4,
    ST_BADLOW     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    DK_NONE = 2'd0,
    DK_RAW  = 2'd1,
    DK_CP   = 2'd2
  } data_kind_t;

  typedef enum logic {
    REG_CHARSET_MODE = 1'b0,
    REG_UNUSED       = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       run_last;
  } out_item_t;

  // One queue entry: what a single character produces.
  typedef struct packed {
    data_kind_t      kind;
    logic [CP_W-1:0] cp;       // raw byte in [7:0] for DK_RAW
    logic            has_err;
    status_t         err_code;
    logic            has_end;
  } desc_t;

endpackage

@@ rtl/ped_front.sv @@
// Front end: escape parser, one character per cycle while the queue is not full, emits a work descriptor.
`timescale 1ns / 1ps

module ped_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ped_pkg::in_item_t in_data,
  input  logic              charset_mode,
  input  logic              q_full,
  output logic              push,
  output ped_pkg::desc_t    push_desc
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PCT,
    PH_HEX2,
    PH_UHI,
    PH_ULO
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [9:0]  high_r, high_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        err_r, err_nxt;

  logic             accept;
  logic             hex_ok;
  logic [3:0]       dval;
  logic [15:0]      acc_new;
  logic             fail;
  ped_pkg::status_t fail_code;
  ped_pkg::desc_t   desc;
  logic [7:0]       c;

  function automatic logic char_allowed(input logic [7:0] ch, input logic wide);
    logic alnum;
    alnum = (ch inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    if (alnum) return 1'b1;
    if (wide)
      return ch inside {8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29,
                        8'h3B, 8'h2F, 8'h3F, 8'h3A, 8'h40, 8'h26, 8'h3D, 8'h2B, 8'h24,
                        8'h2C, 8'h23};
    return ch inside {8'h2E, 8'h2D, 8'h7E, 8'h5F};
  endfunction

  assign c        = in_data.in_char;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // hex digit decode: 0-9, A-F, a-f only
  always_comb begin
    hex_ok = 1'b1;
    dval   = '0;
    if (c inside {[8'h30:8'h39]})      dval = c[3:0];
    else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) dval = c[3:0] + 4'd9;
    else hex_ok = 1'b0;
  end

  assign acc_new = {acc_r[11:0], dval};

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    high_nxt  = high_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    fail      = 1'b0;
    fail_code = ped_pkg::ST_BADHEX;
    desc          = '0;
    desc.kind     = ped_pkg::DK_NONE;
    desc.err_code = ped_pkg::ST_BYTE;
    desc.has_end  = in_data.in_last;

    if (!err_r) begin
      case (phase_r)
        PH_PCT: begin
          if (c == 8'h75 || c == 8'h55) begin
            phase_nxt = PH_UHI;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else if (hex_ok) begin
            acc_nxt   = {12'd0, dval};
            phase_nxt = PH_HEX2;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HEX2: begin
          if (hex_ok) begin
            desc.kind = ped_pkg::DK_RAW;
            desc.cp   = {13'd0, acc_r[3:0], dval};
            phase_nxt = PH_IDLE;
            acc_nxt   = '0;
          end else begin
            fail = 1'b1;
          end
        end
        PH_UHI, PH_ULO: begin
          if (!hex_ok) begin
            fail = 1'b1;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = acc_new;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            acc_nxt = '0;
            if (phase_r == PH_UHI) begin
              if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                high_nxt  = acc_new[9:0];
                phase_nxt = PH_ULO;
              end else begin
                desc.kind = ped_pkg::DK_CP;
                desc.cp   = {5'd0, acc_new};
                phase_nxt = PH_IDLE;
              end
            end else if (acc_new >= 16'hDC00 && acc_new <= 16'hDFFF) begin
              desc.kind = ped_pkg::DK_CP;
              desc.cp   = 21'h10000 + {1'b0, high_r, acc_new[9:0]};
              phase_nxt = PH_IDLE;
            end else begin
              fail      = 1'b1;
              fail_code = ped_pkg::ST_BADLOW;
            end
          end
        end
        default: begin
          if (c == 8'h25) begin
            phase_nxt = PH_PCT;
            acc_nxt   = '0;
            cnt_nxt   = '0;
          end else if (char_allowed(c, charset_mode)) begin
            desc.kind = ped_pkg::DK_RAW;
            desc.cp   = {13'd0, c};
            phase_nxt = PH_IDLE;
          end else begin
            fail      = 1'b1;
            fail_code = ped_pkg::ST_DISALLOWED;
          end
        end
      endcase
    end

    if (fail) begin
      desc.has_err  = 1'b1;
      desc.err_code = fail_code;
      err_nxt       = 1'b1;
      phase_nxt     = PH_IDLE;
      acc_nxt       = '0;
      cnt_nxt       = '0;
    end

    // end of string: flag an open escape, then clear string state
    if (in_data.in_last) begin
      if (!err_nxt && phase_nxt != PH_IDLE) begin
        desc.has_err  = 1'b1;
        desc.err_code = ped_pkg::ST_INCOMPLETE;
      end
      phase_nxt = PH_IDLE;
      acc_nxt   = '0;
      high_nxt  = '0;
      cnt_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  assign push      = accept && (desc.kind != ped_pkg::DK_NONE || desc.has_err || desc.has_end);
  assign push_desc = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      high_r  <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      high_r  <= high_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> phase_r == PH_IDLE)
    else $error("error flag set while inside an escape");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.in_last) |=> (!err_r && phase_r == PH_IDLE && cnt_r == 2'd0))
    else $error("string state not cleared after last character");

endmodule

@@ rtl/ped_queue.sv @@
// Small descriptor queue between parser and byte emitter.
`timescale 1ns / 1ps

module ped_queue #(
  parameter int DEPTH = ped_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ped_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output ped_pkg::desc_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ped_pkg::desc_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push)
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue overflow");

endmodule

@@ rtl/ped_back.sv @@
// Back end: expands descriptors into results, UTF-8 encoding, output register.
`timescale 1ns / 1ps

module ped_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_nonempty,
  input  ped_pkg::desc_t     head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output ped_pkg::out_item_t out_data
);

  logic               out_valid_r;
  ped_pkg::out_item_t out_data_r, res;
  logic [2:0]         seq_r;
  logic [2:0]         ndata, total;
  logic [7:0]         b [4];
  logic               load, is_last;

  // data bytes of the head entry
  always_comb begin
    b[0] = head.cp[7:0];
    b[1] = 8'd0;
    b[2] = 8'd0;
    b[3] = 8'd0;
    ndata = 3'd0;
    case (head.kind)
      ped_pkg::DK_RAW: ndata = 3'd1;
      ped_pkg::DK_CP: begin
        if (head.cp < 21'h80) begin
          ndata = 3'd1;
        end else if (head.cp < 21'h800) begin
          ndata = 3'd2;
          b[0]  = {3'b110, head.cp[10:6]};
          b[1]  = {2'b10, head.cp[5:0]};
        end else if (head.cp < 21'h10000) begin
          ndata = 3'd3;
          b[0]  = {4'b1110, head.cp[15:12]};
          b[1]  = {2'b10, head.cp[11:6]};
          b[2]  = {2'b10, head.cp[5:0]};
        end else begin
          ndata = 3'd4;
          b[0]  = {5'b11110, head.cp[20:18]};
          b[1]  = {2'b10, head.cp[17:12]};
          b[2]  = {2'b10, head.cp[11:6]};
          b[3]  = {2'b10, head.cp[5:0]};
        end
      end
      default: ndata = 3'd0;
    endcase
  end

  assign total   = ndata + {2'd0, head.has_err} + {2'd0, head.has_end};
  assign is_last = (seq_r == total - 3'd1);

  always_comb begin
    res = '0;
    if (seq_r < ndata) begin
      res.status   = ped_pkg::ST_BYTE;
      res.out_byte = b[seq_r[1:0]];
    end else if (head.has_err && seq_r == ndata) begin
      res.status = head.err_code;
    end else begin
      res.status = ped_pkg::ST_END;
    end
    res.run_last = is_last;
  end

  assign load      = q_nonempty && (!out_valid_r || !out_stall);
  assign pop       = load && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seq_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
        seq_r       <= is_last ? 3'd0 : seq_r + 3'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ped_pkg::ST_BYTE) |-> out_data_r.out_byte == 8'd0)
    else $error("non-data result carries a byte");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ped_pkg::ST_END) |-> out_data_r.run_last)
    else $error("end-of-string result not marked last");

endmodule

@@ rtl/percent_escape_decoder_core.sv @@
// Top level of the percent-escape decoder: parser, queue, emitter, APB register.
`timescale 1ns / 1ps
// A character's results reach out_data through the descriptor queue and the output register.
// Throughput: one character per cycle while the queue is not full; the emitter, unless stalled,
//   sends one result per cycle, k per character (up to 5: four UTF-8 bytes and end of string).
// The descriptor queue (QUEUE_DEPTH entries) lets the parser run ahead of long UTF-8 bursts.
// Reset (rst_n low, synchronous): parser idle, queue and output empty, charset_mode 0.

module percent_escape_decoder_core #(
  parameter int QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // character input
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ped_pkg::in_item_t              in_data,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output ped_pkg::out_item_t             out_data,
  // APB configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ped_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic           mode_r;
  logic           cfg_wr;
  logic           push, pop, q_full, q_nonempty;
  ped_pkg::desc_t push_desc, head;

  // Register map: word 0 charset_mode (bit 0); other words read zero, writes ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == ped_pkg::REG_CHARSET_MODE) begin
      mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ped_pkg::REG_CHARSET_MODE) ? {31'd0, mode_r} : 32'd0;

  // Front: parses one character per transfer, classifies it into a descriptor.
  ped_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .charset_mode (mode_r),
    .q_full       (q_full),
    .push         (push),
    .push_desc    (push_desc)
  );

  // Queue: decouples parser stalls from output stalls.
  ped_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (head)
  );

  // Back: UTF-8 expansion and result ordering (bytes, then error, then end).
  ped_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

@@ tb/sv/ped_result_checker.sv @@
// Result checker for the percent-escape decoder: predicts each result from observed transfers.
`timescale 1ns / 1ps

module ped_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ped_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ped_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ped_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             results_pending
);

  typedef enum logic [2:0] {PH_IDLE, PH_PCT, PH_HEX2, PH_UHI, PH_ULO} phase_t;

  localparam logic [15:0] HIGH_FIRST   = 16'hD800;
  localparam logic [15:0] HIGH_LAST    = 16'hDBFF;
  localparam logic [15:0] LOW_FIRST    = 16'hDC00;
  localparam logic [15:0] LOW_LAST     = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam string       NARROW_PUNCT = ".-~_";
  localparam string       WIDE_PUNCT   = "-_.!~*'();/?:@&=+$,#";

  phase_t              phase;
  logic [15:0]         acc;
  logic [15:0]         high_half;
  logic [2:0]          ndig;
  logic                err_seen;
  logic                wide_set;
  int                  fail_tally;
  ped_pkg::out_item_t  want;
  ped_pkg::out_item_t  char_results[$];
  ped_pkg::out_item_t  pending_results[$];

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic logic char_allowed(logic [7:0] c, logic wide);
    string punct;
    punct = wide ? WIDE_PUNCT : NARROW_PUNCT;
    if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
      return 1'b1;
    for (int i = 0; i < punct.len(); i++) begin
      if (punct[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic emit(logic [7:0] b, ped_pkg::status_t st);
    char_results.push_back('{out_byte: (st == ped_pkg::ST_BYTE) ? b : 8'h00,
                             status: st, run_last: 1'b0});
  endtask

  task automatic emit_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], ped_pkg::ST_BYTE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, ped_pkg::ST_BYTE);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[11:6]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, ped_pkg::ST_BYTE);
    end else begin
      emit({5'b11110, cp[20:18]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[17:12]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[11:6]}, ped_pkg::ST_BYTE);
      emit({2'b10, cp[5:0]}, ped_pkg::ST_BYTE);
    end
  endtask

  // first error of a string: one error result, then drop input until the end
  task automatic raise_error(ped_pkg::status_t st);
    emit(8'h00, st);
    err_seen = 1'b1;
    phase    = PH_IDLE;
    acc      = '0;
    ndig     = '0;
  endtask

  task automatic decode_char(logic [7:0] c, logic last);
    int d;
    d = hex_val(c);
    char_results.delete();
    if (!err_seen) begin
      case (phase)
        PH_PCT: begin
          if (c == "u" || c == "U") begin
            phase = PH_UHI;
            acc   = '0;
            ndig  = '0;
          end else if (d >= 0) begin
            acc   = 16'(d);
            phase = PH_HEX2;
          end else begin
            raise_error(ped_pkg::ST_BADHEX);
          end
        end
        PH_HEX2: begin
          if (d >= 0) begin
            emit({acc[3:0], 4'(d)}, ped_pkg::ST_BYTE);
            phase = PH_IDLE;
            acc   = '0;
          end else begin
            raise_error(ped_pkg::ST_BADHEX);
          end
        end
        PH_UHI, PH_ULO: begin
          if (d < 0) begin
            raise_error(ped_pkg::ST_BADHEX);
          end else begin
            acc  = {acc[11:0], 4'(d)};
            ndig = ndig + 3'd1;
            if (ndig == 3'd4) begin
              ndig = '0;
              if (phase == PH_UHI) begin
                if (acc >= HIGH_FIRST && acc <= HIGH_LAST) begin
                  high_half = acc;
                  phase     = PH_ULO;
                end else begin
                  emit_utf8(21'(acc));
                  phase = PH_IDLE;
                end
              end else if (acc >= LOW_FIRST && acc <= LOW_LAST) begin
                emit_utf8(SUPP_BASE + 21'({high_half[9:0], acc[9:0]}));
                phase = PH_IDLE;
              end else begin
                raise_error(ped_pkg::ST_BADLOW);
              end
              acc = '0;
            end
          end
        end
        default: begin
          if (c == "%") begin
            phase = PH_PCT;
            acc   = '0;
            ndig  = '0;
          end else if (char_allowed(c, wide_set)) begin
            emit(c, ped_pkg::ST_BYTE);
          end else begin
            raise_error(ped_pkg::ST_DISALLOWED);
          end
        end
      endcase
    end
    if (last) begin
      if (!err_seen && phase != PH_IDLE) raise_error(ped_pkg::ST_INCOMPLETE);
      emit(8'h00, ped_pkg::ST_END);
      phase     = PH_IDLE;
      acc       = '0;
      high_half = '0;
      ndig      = '0;
      err_seen  = 1'b0;
    end
    if (char_results.size() > 0) char_results[char_results.size() - 1].run_last = 1'b1;
    foreach (char_results[i]) pending_results.push_back(char_results[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase      = PH_IDLE;
      acc        = '0;
      high_half  = '0;
      ndig       = '0;
      err_seen   = 1'b0;
      wide_set   = 1'b0;
      fail_tally = 0;
      pending_results.delete();
    end else begin
      // results first: nothing accepted at this edge can show up at it
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: out_byte %0h status %0d run_last %0b",
                 out_data.out_byte, out_data.status, out_data.run_last);
          fail_tally++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %0h, got %0h",
                   want.out_byte, out_data.out_byte);
            fail_tally++;
          end
          if (out_data.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
            fail_tally++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last mismatch: expected %0b, got %0b",
                   want.run_last, out_data.run_last);
            fail_tally++;
          end
        end
      end
      if (in_valid && !in_stall) decode_char(in_data.in_char, in_data.in_last);
      if (psel && penable && pwrite && pready &&
          paddr[ped_pkg::APB_ADDR_W-1:2] == ped_pkg::REG_CHARSET_MODE) begin
        wide_set = pwdata[0];
      end
    end
    fail_count      <= fail_tally;
    results_pending <= pending_results.size();
  end

endmodule

@@ tb/sv/tb_percent_escape_decoder_core.sv @@
// Testbench top for the percent-escape decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_percent_escape_decoder_core;

  localparam int    CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int    DRAIN_CYCLES = 20;      // settle time after the last result
  localparam string ALNUM = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string PUNCT = "-_.!~*'();/?:@&=+$,#";
  localparam string NOISE = "gGzZx%<> ^{|}\"";

  logic                           clk     = 1'b0;
  logic                           rst_n   = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  ped_pkg::in_item_t              in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  ped_pkg::out_item_t             out_data;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [ped_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [31:0]                    pwdata  = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  int          check_fails;
  int          results_pending;
  int          cycle_count   = 0;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [7:0]  text_q[$];   // characters of the string being built

  always #4 clk = ~clk;

  percent_escape_decoder_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ped_result_checker result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (check_fails),
    .results_pending(results_pending)
  );

  // Receiver back-pressure: a fresh stall decision every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // APB write: setup cycle, then access cycle held until pready.
  // A trailing idle cycle keeps back-to-back writes from touching psel twice in one step.
  task automatic write_reg(ped_pkg::reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ped_pkg::APB_ADDR_W'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Only bit 0 counts; junk in the upper bits checks that it is ignored.
  task automatic set_mode(logic wide);
    write_reg(ped_pkg::REG_CHARSET_MODE, {31'($urandom()), wide});
  endtask

  // One character transfer. Valid is only lowered for a random gap, so it never
  // drops and rises within the same step.
  task automatic send_char(logic [7:0] ch, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_char: ch, in_last: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Send the built string, marking its final character as last.
  task automatic send_queued();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Sender holds off until every predicted result is out, then lets the
  // block settle (characters that give no result may still be in flight).
  task automatic await_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    logic [7:0] ch;
    if (v < 4'd10) ch = "0" + v;
    else ch = ($urandom_range(1) ? "A" : "a") + 8'(v - 4'd10);
    return ch;
  endfunction

  // Most significant nibble first, random letter case.
  task automatic append_hex(logic [15:0] value, int digits);
    for (int i = digits - 1; i >= 0; i--) text_q.push_back(hex_digit(value[i*4 +: 4]));
  endtask

  function automatic logic [7:0] noise_char();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(128, 255));
      1:       return NOISE[$urandom_range(NOISE.len() - 1)];
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One token: mostly well-formed escapes and plain characters, some breakage.
  task automatic add_token();
    int          pick;
    logic [15:0] unit;
    pick = $urandom_range(99);
    if (pick < 35) begin
      if ($urandom_range(9) < 7) text_q.push_back(ALNUM[$urandom_range(ALNUM.len() - 1)]);
      else text_q.push_back(PUNCT[$urandom_range(PUNCT.len() - 1)]);
    end else if (pick < 55) begin
      text_q.push_back("%");
      append_hex(16'($urandom_range(255)), 2);
    end else if (pick < 70) begin
      // BMP code point spread over the 1-, 2- and 3-byte encodings
      case ($urandom_range(3))
        0:       unit = 16'($urandom_range(16'h7F));
        1:       unit = 16'($urandom_range(16'h80, 16'h7FF));
        2:       unit = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        default: unit = 16'($urandom_range(16'h800, 16'hFFFF));
      endcase
      // keep clear of high surrogates here, pairs have their own token
      if (unit >= 16'hD800 && unit <= 16'hDBFF) unit = unit ^ 16'h2000;
      text_q.push_back("%");
      text_q.push_back($urandom_range(1) ? "u" : "U");
      append_hex(unit, 4);
    end else if (pick < 80) begin
      // surrogate pair: eight hex digits after %u
      text_q.push_back("%");
      text_q.push_back($urandom_range(1) ? "u" : "U");
      append_hex({6'b110110, 10'($urandom_range(1023))}, 4);
      append_hex({6'b110111, 10'($urandom_range(1023))}, 4);
    end else if (pick < 85) begin
      // low surrogate on its own
      text_q.push_back("%");
      text_q.push_back("u");
      append_hex({6'b110111, 10'($urandom_range(1023))}, 4);
    end else begin
      case ($urandom_range(3))
        0: begin
          text_q.push_back("%");
          text_q.push_back(noise_char());
        end
        1: text_q.push_back(noise_char());
        2: begin
          // high half followed by something that is not a low half
          text_q.push_back("%");
          text_q.push_back("U");
          append_hex({6'b110110, 10'($urandom_range(1023))}, 4);
          append_hex(16'($urandom_range(16'hDBFF)), 4);
        end
        default: begin
          text_q.push_back("%");
          text_q.push_back("u");
          append_hex(16'($urandom_range(16'hFFF)), $urandom_range(3));
          text_q.push_back(noise_char());
        end
      endcase
    end
  endtask

  // A string of a few tokens; now and then it ends inside an open escape.
  task automatic build_string();
    int n_tokens;
    n_tokens = $urandom_range(1, 5);
    repeat (n_tokens) add_token();
    if ($urandom_range(9) == 0) begin
      text_q.push_back("%");
      case ($urandom_range(3))
        0:       begin end
        1:       append_hex(16'($urandom_range(15)), 1);
        2: begin
          text_q.push_back("u");
          append_hex(16'($urandom_range(16'hFFF)), 3);
        end
        default: begin
          text_q.push_back("U");
          append_hex({6'b110110, 10'($urandom_range(1023))}, 4);
        end
      endcase
    end
  endtask

  task automatic run_random_strings(int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      build_string();
      send_queued();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // phase one: slow sender, heavily stalled receiver
    send_idle_pct = 37;
    recv_idle_pct = 81;
    write_reg(ped_pkg::REG_UNUSED, 32'hFFFF_FFFF);   // must leave charset_mode alone
    set_mode(1'b0);

    // directed strings, narrow set
    push_text("%UDC00");       // lone low half, capital U: three bytes
    send_queued();
    push_text("%uDBFFDFFF");   // highest pair: four bytes
    send_queued();
    push_text("%00%G");        // data byte zero, then a non-hex digit
    send_queued();
    text_q.push_back(8'h00);   // raw zero is disallowed, the rest is dropped
    text_q.push_back("x");
    send_queued();
    text_q.push_back(8'hFF);   // top-bit byte alone in its string
    send_queued();
    push_text("%4");           // string ends with the escape open
    send_queued();
    push_text("*");            // punctuation only the wide set takes
    send_queued();
    await_idle();
    set_mode(1'b1);
    push_text("*");
    send_queued();
    run_random_strings(75);

    // phase two: the other way round, narrow set
    await_idle();
    send_idle_pct = 81;
    recv_idle_pct = 37;
    set_mode(1'b0);
    run_random_strings(75);

    // phase three: full rate both ways, with a drained pause half way
    await_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_mode(1'b1);
    run_random_strings(35);
    await_idle();
    set_mode(1'b0);
    run_random_strings(35);

    await_idle();
    if (check_fails == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ped_pkg.sv
rtl/ped_front.sv
rtl/ped_queue.sv
rtl/ped_back.sv
rtl/percent_escape_decoder_core.sv
tb/sv/ped_result_checker.sv
tb/sv/tb_percent_escape_decoder_core.sv
